// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tccs_pkg.sv =====
// Types and constants of the text console with cursor and scroll.
package tccs_pkg;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_WRITE   = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_NEWLINE = 3'd3,
    OP_READ    = 3'd4
  } tccs_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL
  } tccs_state_t;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] FILL_CODE  = 8'h00;

endpackage

// ===== rtl/core/text_console_cursor_scroll.sv =====
// Text console: screen cell store with cursor, scroll, clear and cell read.
//
// Timing for a user of the block: a command beat is taken when start is high and busy
// is low, and exactly one result beat follows, shown for a single cycle with out_valid
// high; there is no way to hold it off, so sample it when it appears. Newline, clear,
// spare codes, out-of-range commands, reads of a row not written since the last reset,
// clear or scroll, and puts or positioned writes into a row that already holds data
// answer in the cycle after acceptance without raising busy, so they run at one command
// per cycle. A read of a written row waits on the registered read of the cell memory
// and raises busy meanwhile. The first put or positioned write into a blank
// row raises busy while the row is swept through the single write port of the memory,
// one cell per cycle, before it holds real data. A put that scrolls always lands on such
// a blank row. Scroll and clear themselves cost no sweep: the screen is a ring of rows
// behind a base pointer, and each physical row has a flag that says whether it holds
// real data or reads as its fill (zero after reset and scroll, space in the clear color
// after clear). Reset needs no clearing pass over the memory.
module text_console_cursor_scroll #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_character,
  input  logic [7:0] in_color,
  input  logic [6:0] in_column,
  input  logic [4:0] in_row,
  output logic       out_valid,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_color,
  output logic [6:0] out_cursor_column,
  output logic [4:0] out_cursor_row,
  output logic       out_scrolled,
  output logic       out_ignored
);

`include "assert_macros.svh"

  // Cursor column runs to COLS, cursor row to ROWS; physical rows and columns index
  // the store.
  localparam int CW    = $clog2(COLS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int LW    = RW + 1;
  localparam int PW    = $clog2(ROWS);
  localparam int CIW   = $clog2(COLS);
  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tccs_pkg::tccs_state_t state_r, state_nxt;

  logic [CW-1:0]   cursor_col_r, cursor_col_nxt;
  logic [RW-1:0]   cursor_line_r, cursor_line_nxt;
  logic [PW-1:0]   base_r, base_nxt;
  logic [ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [ROWS-1:0] row_blank_r, row_blank_nxt;
  logic [7:0]      clr_color_r, clr_color_nxt;
  logic [CIW-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [CIW-1:0]  tgt_col_r, tgt_col_nxt;
  logic [PW-1:0]   tgt_row_r, tgt_row_nxt;
  logic [15:0]     tgt_cell_r, tgt_cell_nxt;
  logic            pend_scroll_r, pend_scroll_nxt;

  logic            out_valid_nxt;
  logic [7:0]      out_cell_char_nxt, out_cell_color_nxt;
  logic [6:0]      out_cursor_column_nxt;
  logic [4:0]      out_cursor_row_nxt;
  logic            out_scrolled_nxt, out_ignored_nxt;

  // Cell memory: color in the high byte, character in the low byte.
  logic [15:0]   mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   rd_data_r;

  // Put cursor arithmetic and position decode.
  logic          put_wrap, put_scroll;
  logic [CW-1:0] put_col;
  logic [LW-1:0] put_line;
  logic [PW-1:0] put_row, put_base, put_phys, base_inc;
  logic          pos_ok;
  logic [PW-1:0] pos_phys;
  logic [AW-1:0] pos_addr, put_addr;
  logic [15:0]   in_cell;
  logic [15:0]   pos_fill;

  // Logical row to physical row in the ring that starts at the base row.
  function automatic logic [PW-1:0] map_row(input logic [PW-1:0] b,
                                            input logic [PW-1:0] l);
    logic [PW:0] s;
    s = {1'b0, b} + {1'b0, l};
    if (s >= (PW + 1)'(ROWS)) begin
      s = s - (PW + 1)'(ROWS);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] r,
                                              input logic [CIW-1:0] c);
    return AW'(AW'(r) * AW'(COLS)) + AW'(c);
  endfunction

  function automatic logic [15:0] fill_cell(input logic blank, input logic [7:0] color);
    return blank ? {color, tccs_pkg::BLANK_CHAR} : {tccs_pkg::FILL_CODE, tccs_pkg::FILL_CODE};
  endfunction

  always_comb begin
    put_wrap   = cursor_col_r >= CW'(COLS);
    put_col    = put_wrap ? '0 : cursor_col_r;
    put_line   = put_wrap ? LW'(cursor_line_r) + LW'(1) : LW'(cursor_line_r);
    put_scroll = put_line >= LW'(ROWS);
    put_row    = put_scroll ? PW'(ROWS - 1) : put_line[PW-1:0];
    base_inc   = (base_r == PW'(ROWS - 1)) ? '0 : base_r + PW'(1);
    put_base   = put_scroll ? base_inc : base_r;
    put_phys   = map_row(put_base, put_row);
    put_addr   = cell_addr(put_phys, put_col[CIW-1:0]);
    pos_ok     = ({1'b0, in_column} < 8'(COLS)) && ({1'b0, in_row} < 6'(ROWS));
    pos_phys   = map_row(base_r, PW'(in_row));
    pos_addr   = cell_addr(pos_phys, CIW'(in_column));
    pos_fill   = fill_cell(row_blank_r[pos_phys], clr_color_r);
    in_cell    = {in_color, in_character};
  end

  // Next state, memory port control and result beat.
  always_comb begin
    state_nxt          = state_r;
    cursor_col_nxt     = cursor_col_r;
    cursor_line_nxt    = cursor_line_r;
    base_nxt           = base_r;
    row_valid_nxt      = row_valid_r;
    row_blank_nxt      = row_blank_r;
    clr_color_nxt      = clr_color_r;
    fill_cnt_nxt       = fill_cnt_r;
    tgt_col_nxt        = tgt_col_r;
    tgt_row_nxt        = tgt_row_r;
    tgt_cell_nxt       = tgt_cell_r;
    pend_scroll_nxt    = pend_scroll_r;
    mem_we             = 1'b0;
    mem_waddr          = pos_addr;
    mem_wdata          = in_cell;
    mem_raddr          = pos_addr;
    out_valid_nxt      = 1'b0;
    out_cell_char_nxt  = '0;
    out_cell_color_nxt = '0;
    out_scrolled_nxt   = 1'b0;
    out_ignored_nxt    = 1'b0;
    busy               = (state_r != tccs_pkg::ST_IDLE);

    case (state_r)
      tccs_pkg::ST_IDLE: begin
        if (start) begin
          case (tccs_pkg::tccs_op_t'(in_operation))
            tccs_pkg::OP_PUT: begin
              cursor_col_nxt  = put_col + CW'(1);
              cursor_line_nxt = RW'(put_row);
              base_nxt        = put_base;
              if (put_scroll) begin
                // The old top row becomes the new bottom row and reads as zero.
                row_valid_nxt[base_r] = 1'b0;
                row_blank_nxt[base_r] = 1'b0;
              end
              if (!put_scroll && row_valid_r[put_phys]) begin
                mem_we        = 1'b1;
                mem_waddr     = put_addr;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt       = tccs_pkg::ST_FILL;
                fill_cnt_nxt    = '0;
                tgt_col_nxt     = put_col[CIW-1:0];
                tgt_row_nxt     = put_phys;
                tgt_cell_nxt    = in_cell;
                pend_scroll_nxt = put_scroll;
              end
            end
            tccs_pkg::OP_WRITE: begin
              if (!pos_ok) begin
                out_valid_nxt   = 1'b1;
                out_ignored_nxt = 1'b1;
              end else if (row_valid_r[pos_phys]) begin
                mem_we        = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt       = tccs_pkg::ST_FILL;
                fill_cnt_nxt    = '0;
                tgt_col_nxt     = CIW'(in_column);
                tgt_row_nxt     = pos_phys;
                tgt_cell_nxt    = in_cell;
                pend_scroll_nxt = 1'b0;
              end
            end
            tccs_pkg::OP_CLEAR: begin
              row_valid_nxt = '0;
              row_blank_nxt = '1;
              clr_color_nxt = in_color;
              out_valid_nxt = 1'b1;
            end
            tccs_pkg::OP_NEWLINE: begin
              cursor_col_nxt = '0;
              if (cursor_line_r < RW'(ROWS)) begin
                cursor_line_nxt = cursor_line_r + RW'(1);
              end
              out_valid_nxt = 1'b1;
            end
            tccs_pkg::OP_READ: begin
              if (!pos_ok) begin
                out_valid_nxt   = 1'b1;
                out_ignored_nxt = 1'b1;
              end else if (!row_valid_r[pos_phys]) begin
                out_valid_nxt      = 1'b1;
                out_cell_char_nxt  = pos_fill[7:0];
                out_cell_color_nxt = pos_fill[15:8];
              end else begin
                state_nxt = tccs_pkg::ST_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      tccs_pkg::ST_READ: begin
        state_nxt          = tccs_pkg::ST_IDLE;
        out_valid_nxt      = 1'b1;
        out_cell_char_nxt  = rd_data_r[7:0];
        out_cell_color_nxt = rd_data_r[15:8];
      end
      tccs_pkg::ST_FILL: begin
        // Sweep the target row: fill pattern everywhere but the written cell.
        mem_we       = 1'b1;
        mem_waddr    = cell_addr(tgt_row_r, fill_cnt_r);
        mem_wdata    = (fill_cnt_r == tgt_col_r) ? tgt_cell_r :
                       fill_cell(row_blank_r[tgt_row_r], clr_color_r);
        fill_cnt_nxt = fill_cnt_r + CIW'(1);
        if (fill_cnt_r == CIW'(COLS - 1)) begin
          row_valid_nxt[tgt_row_r] = 1'b1;
          state_nxt                = tccs_pkg::ST_IDLE;
          out_valid_nxt            = 1'b1;
          out_scrolled_nxt         = pend_scroll_r;
        end
      end
      default: begin
        state_nxt = tccs_pkg::ST_IDLE;
      end
    endcase

    if (state_r == tccs_pkg::ST_IDLE && start &&
        tccs_pkg::tccs_op_t'(in_operation) == tccs_pkg::OP_PUT) begin
      out_scrolled_nxt = put_scroll;
    end
    out_cursor_column_nxt = 7'(cursor_col_nxt);
    out_cursor_row_nxt    = 5'(cursor_line_nxt);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tccs_pkg::ST_IDLE;
      cursor_col_r  <= '0;
      cursor_line_r <= '0;
      base_r        <= '0;
      row_valid_r   <= '0;
      row_blank_r   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_line_r <= cursor_line_nxt;
      base_r        <= base_nxt;
      row_valid_r   <= row_valid_nxt;
      row_blank_r   <= row_blank_nxt;
      out_valid     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_color_r       <= clr_color_nxt;
    fill_cnt_r        <= fill_cnt_nxt;
    tgt_col_r         <= tgt_col_nxt;
    tgt_row_r         <= tgt_row_nxt;
    tgt_cell_r        <= tgt_cell_nxt;
    pend_scroll_r     <= pend_scroll_nxt;
    out_cell_char     <= out_cell_char_nxt;
    out_cell_color    <= out_cell_color_nxt;
    out_cursor_column <= out_cursor_column_nxt;
    out_cursor_row    <= out_cursor_row_nxt;
    out_scrolled      <= out_scrolled_nxt;
    out_ignored       <= out_ignored_nxt;
  end

  `ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, out_valid || busy,
               "accepted command neither answered nor in progress")
  `ASSERT_NEXT(a_read_latency, clk, rst_n, state_r == tccs_pkg::ST_READ,
               out_valid && state_r == tccs_pkg::ST_IDLE,
               "memory read did not answer after one cycle")
  `ASSERT_NEXT(a_fill_done, clk, rst_n,
               state_r == tccs_pkg::ST_FILL && fill_cnt_r == CIW'(COLS - 1),
               out_valid && row_valid_r[$past(tgt_row_r)],
               "row sweep ended without result or valid row")
  `ASSERT_IMPLIES(a_write_owner, clk, rst_n, mem_we,
                  state_r == tccs_pkg::ST_FILL || (start && !busy),
                  "memory written outside a command")

endmodule
